[hw/rtl/ales_pkg.sv]
// Shared types and constants for the addressable LED serial encoder.
// No dependencies; every other file of the block imports this package.
package ales_pkg;

    // Bits shifted out per colour byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd1;
    localparam logic [1:0] REG_BIT_PERIOD = 2'd2;
    localparam logic [1:0] REG_LATCH      = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd5;
    localparam logic [7:0]  RST_ONE_HIGH   = 8'd13;
    localparam logic [7:0]  RST_BIT_PERIOD = 8'd20;
    localparam logic [15:0] RST_LATCH      = 16'd816;

    // Bus widths
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Timing configuration
    typedef struct packed {
        logic [7:0]  zero_high_ticks;
        logic [7:0]  one_high_ticks;
        logic [7:0]  bit_period_ticks;
        logic [15:0] latch_ticks;
    } t_cfg;

    // One input transaction
    typedef struct packed {
        logic       action;      // 0 = tick, 1 = offer a byte
        logic [7:0] data_byte;
        logic       frame_last;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic busy_res;
        logic holding_free;
        logic byte_accepted;
        logic line_level;
    } t_result;

endpackage

[hw/rtl/ales_apb_regs.sv]
// APB register file holding the bit and latch timing of the encoder.
// Depends on ales_pkg for register indexes, reset values and t_cfg.
module ales_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ales_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ales_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ales_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ales_pkg::t_cfg                 o_cfg
);
    import ales_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Write the addressed register in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high_ticks  <= RST_ZERO_HIGH;
            r_cfg.one_high_ticks   <= RST_ONE_HIGH;
            r_cfg.bit_period_ticks <= RST_BIT_PERIOD;
            r_cfg.latch_ticks      <= RST_LATCH;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ZERO_HIGH:  r_cfg.zero_high_ticks  <= pwdata[7:0];
                REG_ONE_HIGH:   r_cfg.one_high_ticks   <= pwdata[7:0];
                REG_BIT_PERIOD: r_cfg.bit_period_ticks <= pwdata[7:0];
                REG_LATCH:      r_cfg.latch_ticks      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_ZERO_HIGH:  prdata = {24'd0, r_cfg.zero_high_ticks};
            REG_ONE_HIGH:   prdata = {24'd0, r_cfg.one_high_ticks};
            REG_BIT_PERIOD: prdata = {24'd0, r_cfg.bit_period_ticks};
            REG_LATCH:      prdata = {16'd0, r_cfg.latch_ticks};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ales_in_reg.sv]
// Input register: captures one transaction from the upstream stream side.
// Depends on ales_pkg for t_item.
module ales_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ales_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output ales_pkg::t_item o_item
);
    import ales_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Take a new transaction when empty or when the held one moves on this cycle
    assign o_ready = ~r_valid | i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/ales_core.sv]
// Encoder core: shifter, holding register, bit and latch timers, line level.
// Depends on ales_pkg for t_cfg, t_item, t_result and BITS_PER_BYTE.
module ales_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ales_pkg::t_item   i_item,
    input  ales_pkg::t_cfg    i_cfg,
    output ales_pkg::t_result o_result
);
    import ales_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_shift_byte,  n_shift_byte;
    logic        r_shift_last,  n_shift_last;
    logic [3:0]  r_bits_left,   n_bits_left;
    logic [7:0]  r_tick_in_bit, n_tick_in_bit;
    logic [15:0] r_latch_count, n_latch_count;
    logic [7:0]  r_hold_byte,   n_hold_byte;
    logic        r_hold_last,   n_hold_last;
    logic        r_hold_full,   n_hold_full;
    logic        r_line_out,    n_line_out;
    logic        accepted;
    logic [7:0]  high_ticks;
    logic [7:0]  tick_inc;
    logic [15:0] latch_inc;

    // Work out the state after one transaction
    always_comb begin
        n_phase       = r_phase;
        n_shift_byte  = r_shift_byte;
        n_shift_last  = r_shift_last;
        n_bits_left   = r_bits_left;
        n_tick_in_bit = r_tick_in_bit;
        n_latch_count = r_latch_count;
        n_hold_byte   = r_hold_byte;
        n_hold_last   = r_hold_last;
        n_hold_full   = r_hold_full;
        n_line_out    = r_line_out;
        accepted      = 1'b0;
        high_ticks    = '0;
        tick_inc      = '0;
        latch_inc     = '0;

        if (i_item.action) begin
            // Offer: fill the holding register if it is empty
            if (!r_hold_full) begin
                n_hold_byte = i_item.data_byte;
                n_hold_last = i_item.frame_last;
                n_hold_full = 1'b1;
                accepted    = 1'b1;
            end
        end else begin
            // Tick: start a byte when idle with one waiting
            if (r_phase == PH_IDLE && r_hold_full) begin
                n_shift_byte  = r_hold_byte;
                n_shift_last  = r_hold_last;
                n_hold_full   = 1'b0;
                n_bits_left   = BITS_PER_BYTE;
                n_tick_in_bit = '0;
                n_phase       = PH_SEND;
            end

            n_line_out = 1'b0;
            case (n_phase)
                PH_SEND: begin
                    high_ticks = n_shift_byte[7] ? i_cfg.one_high_ticks
                                                 : i_cfg.zero_high_ticks;
                    n_line_out = (n_tick_in_bit < high_ticks);
                    tick_inc   = n_tick_in_bit + 8'd1;
                    if (tick_inc >= i_cfg.bit_period_ticks || tick_inc == 8'd0) begin
                        // End of bit: advance the shifter
                        n_tick_in_bit = '0;
                        n_shift_byte  = {n_shift_byte[6:0], 1'b0};
                        n_bits_left   = n_bits_left - 4'd1;
                        if (n_bits_left == 4'd0) begin
                            if (n_shift_last) begin
                                n_phase       = PH_LATCH;
                                n_latch_count = '0;
                            end else if (n_hold_full) begin
                                // Refill from the holding register without a gap
                                n_shift_byte  = r_hold_byte;
                                n_shift_last  = r_hold_last;
                                n_hold_full   = 1'b0;
                                n_bits_left   = BITS_PER_BYTE;
                                n_phase       = PH_SEND;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end else begin
                        n_tick_in_bit = tick_inc;
                    end
                end
                PH_LATCH: begin
                    latch_inc = r_latch_count + 16'd1;
                    if (latch_inc >= i_cfg.latch_ticks || latch_inc == 16'd0) begin
                        n_latch_count = '0;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_latch_count = latch_inc;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Hold encoder state; advance once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_shift_byte  <= '0;
            r_shift_last  <= 1'b0;
            r_bits_left   <= '0;
            r_tick_in_bit <= '0;
            r_latch_count <= '0;
            r_hold_last   <= 1'b0;
            r_hold_full   <= 1'b0;
            r_line_out    <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_shift_byte  <= n_shift_byte;
            r_shift_last  <= n_shift_last;
            r_bits_left   <= n_bits_left;
            r_tick_in_bit <= n_tick_in_bit;
            r_latch_count <= n_latch_count;
            r_hold_last   <= n_hold_last;
            r_hold_full   <= n_hold_full;
            r_line_out    <= n_line_out;
        end
    end

    // Holding byte is only read while full, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hold_byte <= n_hold_byte;
        end
    end

    assign o_result.line_level    = n_line_out;
    assign o_result.byte_accepted = accepted;
    assign o_result.holding_free  = ~n_hold_full;
    assign o_result.busy_res      = (n_phase != PH_IDLE);

endmodule

[hw/rtl/ales_out_reg.sv]
// Result register: holds one result transaction for the downstream side.
// Depends on ales_pkg for t_result.
module ales_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ales_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_valid,
    input  logic             i_ready,
    output ales_pkg::t_result o_result
);
    import ales_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Move on when empty or when the held result is taken
    assign o_advance = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hw/rtl/addressable_led_serial_encoder.sv]
// Channel   | Direction | Handshake               | Carries
// s_axis    | in        | tvalid/tready           | tdata=data_byte, tlast=frame_last, tuser=action
// m_axis    | out       | tvalid/tready           | tdata=line, accepted, free, busy
// apb       | in        | psel/penable, pready=1  | four timing registers at 0x0..0xC
//
// One transaction per clock unless m_axis stalls: input register, one pass of encoder
// logic, result register. A result is offered on m_axis once its input transaction has
// passed the input register and then the result register.
// Reset is synchronous, active low; the registers take their default timing.
// A stall on m_axis holds the result register and then the input register,
// and s_axis tready drops only while both stages are full.
//
// Top level of the addressable LED serial encoder.
// Depends on ales_pkg, ales_apb_regs, ales_in_reg, ales_core and ales_out_reg.
module addressable_led_serial_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ales_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ales_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ales_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] data_byte
    input  logic                            i_s_axis_tlast,  // frame_last
    input  logic                            i_s_axis_tuser,  // [0] action
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] line_level, [1] byte_accepted, [2] holding_free, [3] busy_res, [7:4] zero
    output logic [7:0]                      o_m_axis_tdata
);
    import ales_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    t_result core_result;
    t_result out_result;
    logic    held_valid;
    logic    advance;
    logic    fire;

    assign in_item.action     = i_s_axis_tuser;
    assign in_item.data_byte  = i_s_axis_tdata;
    assign in_item.frame_last = i_s_axis_tlast;

    ales_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ales_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Process the held transaction when the result register can take it
    assign fire = held_valid & advance;

    ales_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    ales_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_result  (core_result),
        .o_advance (advance),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (out_result)
    );

    assign o_m_axis_tdata = {4'd0, out_result};

endmodule

[hw/rtl/ales_checker.sv]
// Port-level checks for the addressable LED serial encoder, bound to the top level.
// Depends on ales_pkg for bus widths and register indexes.
module ales_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [ales_pkg::APB_ADDR_W-1:0] paddr,
    input logic [ales_pkg::APB_DATA_W-1:0] pwdata,
    input logic [ales_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [7:0]                      o_m_axis_tdata
);
    import ales_pkg::*;

    // No result is offered in the cycle after reset
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // An empty result side always leaves the input side open
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while result register is empty");

    // A stalled result stays offered
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Zero-bit high time reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr == {REG_ZERO_HIGH, 2'b00})
        |=> (!(paddr == {REG_ZERO_HIGH, 2'b00}) || pwrite
             || prdata[7:0] == $past(pwdata[7:0])))
        else $error("register read back differs from last write");

endmodule

bind addressable_led_serial_encoder ales_checker u_ales_checker (.*);

[bench/tb_addressable_led_serial_encoder.sv]
// Self-checking bench for the addressable LED serial encoder: streams tick and byte-offer
// transactions, predicts every result transaction in a behavioral encoder model, compares.
// Depends on ales_pkg and the addressable_led_serial_encoder RTL.
`timescale 1ns / 100ps

module tb_addressable_led_serial_encoder;
    import ales_pkg::*;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    localparam int CLK_HALF_NS      = 10;
    localparam int RST_CYCLES       = 10;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_START  = 300;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int TICK_CHUNK       = 16;

    typedef enum logic [1:0] {
        ENC_IDLE  = 2'd0,
        ENC_SEND  = 2'd1,
        ENC_LATCH = 2'd2
    } t_enc_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;  // [7:0] data_byte
    logic                  i_s_axis_tlast;  // frame_last
    logic                  i_s_axis_tuser;  // [0] action
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [0] line_level, [1] byte_accepted, [2] holding_free, [3] busy_res, [7:4] zero
    logic [7:0]            o_m_axis_tdata;

    addressable_led_serial_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Encoder model state and timing registers
    t_cfg       mdl_cfg;
    t_enc_phase enc_phase;
    logic [7:0]  shift_byte;
    logic        shift_last;
    logic [3:0]  bits_left;
    logic [7:0]  tick_in_bit;
    logic [15:0] latch_count;
    logic [7:0]  hold_byte;
    logic        hold_last;
    logic        hold_full;
    logic        line_out;

    t_item   pending_items[$];
    t_result expected_results[$];
    t_item   tx_item;

    logic        s_fire;
    logic        burst_mode;
    int unsigned tx_gap;
    int unsigned rx_stall;
    int unsigned rx_long_left;
    logic        rx_long_done;

    int items_in;
    int results_seen;
    int bytes_taken;
    int frames_latched;
    int settings_run;
    int fail_count;

    // Move the holding byte into the shifter and start its first bit
    function automatic void load_shifter();
        shift_byte  = hold_byte;
        shift_last  = hold_last;
        hold_full   = 1'b0;
        bits_left   = BITS_PER_BYTE;
        tick_in_bit = 8'd0;
        enc_phase   = ENC_SEND;
    endfunction

    // Advance the encoder model by one transaction and return the line status it produces
    function automatic t_result encode_step(t_item it);
        t_result    res;
        logic       taken;
        logic       level;
        logic [7:0] high_ticks;
        taken = 1'b0;
        level = 1'b0;
        if (it.action == ACT_OFFER) begin
            if (!hold_full) begin
                hold_byte = it.data_byte;
                hold_last = it.frame_last;
                hold_full = 1'b1;
                taken     = 1'b1;
                bytes_taken++;
            end
        end else begin
            if (enc_phase == ENC_IDLE && hold_full)
                load_shifter();
            if (enc_phase == ENC_SEND) begin
                high_ticks  = shift_byte[7] ? mdl_cfg.one_high_ticks : mdl_cfg.zero_high_ticks;
                level       = (tick_in_bit < high_ticks);
                tick_in_bit = tick_in_bit + 8'd1;
                if (tick_in_bit >= mdl_cfg.bit_period_ticks || tick_in_bit == 8'd0) begin
                    tick_in_bit = 8'd0;
                    shift_byte  = {shift_byte[6:0], 1'b0};
                    bits_left   = bits_left - 4'd1;
                    if (bits_left == 4'd0) begin
                        if (shift_last) begin
                            enc_phase   = ENC_LATCH;
                            latch_count = 16'd0;
                            frames_latched++;
                        end else if (hold_full) begin
                            load_shifter();
                        end else begin
                            // underrun: rest low until the next byte shows up
                            enc_phase = ENC_IDLE;
                        end
                    end
                end
            end else if (enc_phase == ENC_LATCH) begin
                latch_count = latch_count + 16'd1;
                if (latch_count >= mdl_cfg.latch_ticks || latch_count == 16'd0) begin
                    latch_count = 16'd0;
                    enc_phase   = ENC_IDLE;
                end
            end
            line_out = level;
        end
        res.line_level    = line_out;
        res.byte_accepted = taken;
        res.holding_free  = !hold_full;
        res.busy_res      = (enc_phase != ENC_IDLE);
        return res;
    endfunction

    function automatic t_item tick_item();
        t_item it;
        it.action     = ACT_TICK;
        it.data_byte  = 8'($urandom());
        it.frame_last = ($urandom_range(0, 1) != 0);
        return it;
    endfunction

    function automatic t_item offer_item(logic [7:0] data, logic last);
        t_item it;
        it.action     = ACT_OFFER;
        it.data_byte  = data;
        it.frame_last = last;
        return it;
    endfunction

    // Mostly short gaps, now and then a long one; none in burst stretches
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Clock
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Offer pending transactions on the input stream
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || s_fire)) begin
            if (tx_gap != 0) begin
                tx_gap          <= tx_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                tx_item         <= pending_items[0];
                i_s_axis_tuser  <= pending_items[0].action;
                i_s_axis_tdata  <= pending_items[0].data_byte;
                i_s_axis_tlast  <= pending_items[0].frame_last;
                i_s_axis_tvalid <= 1'b1;
                tx_gap          <= pick_idle();
                void'(pending_items.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result stream backpressure, with one long hold-off while the input keeps coming
    always @(negedge i_clk) begin
        if (rx_long_left != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_long_left    <= rx_long_left - 1;
        end else if (!rx_long_done && items_in >= LONG_HOLD_START) begin
            i_m_axis_tready <= 1'b0;
            rx_long_left    <= LONG_HOLD_CYCLES - 1;
            rx_long_done    <= 1'b1;
        end else if (rx_stall != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall        <= rx_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_stall        <= pick_idle();
        end
    end

    // Check results against the oldest expectation, then predict for new input transactions
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            s_fire <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata[3:0];
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: tdata=%h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("line_level", want.line_level, got.line_level);
                    check_field("byte_accepted", want.byte_accepted, got.byte_accepted);
                    check_field("holding_free", want.holding_free, got.holding_free);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    results_seen++;
                end
            end
            s_fire <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(encode_step(tx_item));
                items_in++;
            end
        end
    end

    // Read a register and compare with what it should hold
    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (rd !== want) begin
            $error("register %0d: expected %0h, actual %0h", idx, want, rd);
            fail_count++;
        end
    endtask

    // Write a register, mirror it in the model, read it back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_ZERO_HIGH:  mdl_cfg.zero_high_ticks  = val[7:0];
            REG_ONE_HIGH:   mdl_cfg.one_high_ticks   = val[7:0];
            REG_BIT_PERIOD: mdl_cfg.bit_period_ticks = val[7:0];
            REG_LATCH:      mdl_cfg.latch_ticks      = val[15:0];
            default: ;
        endcase
        check_reg(idx, val);
    endtask

    task automatic set_timing(input logic [7:0] zh, input logic [7:0] oh,
                              input logic [7:0] per, input logic [15:0] lat);
        write_reg(REG_ZERO_HIGH, 32'(zh));
        write_reg(REG_ONE_HIGH, 32'(oh));
        write_reg(REG_BIT_PERIOD, 32'(per));
        write_reg(REG_LATCH, 32'(lat));
        settings_run++;
    endtask

    // Hold the sender until every queued transaction has gone through and been checked
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
    endtask

    // Tick until the encoder has nothing in flight, so timing can change safely
    task automatic settle_encoder();
        int k;
        burst_mode = 1'b1;
        wait_drained();
        while (enc_phase != ENC_IDLE || hold_full) begin
            for (k = 0; k < TICK_CHUNK; k++)
                pending_items.push_back(tick_item());
            wait_drained();
        end
        burst_mode = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One timing setting with a random mix of ticks and offers
    task automatic run_setting(input logic [7:0] zh, input logic [7:0] oh,
                               input logic [7:0] per, input logic [15:0] lat,
                               input int n_items, input bit with_lasts,
                               input bit no_idle, input bit close_frame);
        int          k;
        int unsigned span;
        bit          offer;
        t_item       it;
        set_timing(zh, oh, per, lat);
        span       = (per < 8'd2) ? 6 : 6 * int'(per);
        burst_mode = no_idle;
        for (k = 0; k < n_items; k++) begin
            offer = (k == 0) || ($urandom_range(0, span) == 0) || ($urandom_range(0, 19) == 0);
            if (offer) begin
                it = offer_item(8'($urandom()), with_lasts && ($urandom_range(0, 7) == 0));
            end else begin
                it = tick_item();
            end
            pending_items.push_back(it);
        end
        wait_drained();
        settle_encoder();
        if (close_frame) begin
            pending_items.push_back(offer_item(8'($urandom()), 1'b1));
            settle_encoder();
        end
    endtask

    initial begin : stimulus
        int k;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        i_s_axis_tuser  = ACT_TICK;
        i_m_axis_tready = 1'b0;
        tx_item         = '0;
        s_fire          = 1'b0;
        burst_mode      = 1'b0;
        tx_gap          = 0;
        rx_stall        = 0;
        rx_long_left    = 0;
        rx_long_done    = 1'b0;
        items_in        = 0;
        results_seen    = 0;
        bytes_taken     = 0;
        frames_latched  = 0;
        settings_run    = 0;
        fail_count      = 0;
        mdl_cfg.zero_high_ticks  = RST_ZERO_HIGH;
        mdl_cfg.one_high_ticks   = RST_ONE_HIGH;
        mdl_cfg.bit_period_ticks = RST_BIT_PERIOD;
        mdl_cfg.latch_ticks      = RST_LATCH;
        enc_phase   = ENC_IDLE;
        shift_byte  = 8'd0;
        shift_last  = 1'b0;
        bits_left   = 4'd0;
        tick_in_bit = 8'd0;
        latch_count = 16'd0;
        hold_byte   = 8'd0;
        hold_last   = 1'b0;
        hold_full   = 1'b0;
        line_out    = 1'b0;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers come out of reset with the default timing
        check_reg(REG_ZERO_HIGH, 32'(RST_ZERO_HIGH));
        check_reg(REG_ONE_HIGH, 32'(RST_ONE_HIGH));
        check_reg(REG_BIT_PERIOD, 32'(RST_BIT_PERIOD));
        check_reg(REG_LATCH, 32'(RST_LATCH));

        // Directed: one-tick bits, a one that stays high the whole bit, zero-length latch
        set_timing(8'd1, 8'd255, 8'd1, 16'd0);
        pending_items.push_back(tick_item());                 // idle tick, nothing to send
        pending_items.push_back(offer_item(8'hA5, 1'b0));
        pending_items.push_back(offer_item(8'h00, 1'b1));     // refused, holding full
        pending_items.push_back(tick_item());                 // load and send in one tick
        pending_items.push_back(offer_item(8'hFF, 1'b1));
        for (k = 0; k < 15; k++)
            pending_items.push_back(tick_item());             // refill without a gap, then latch
        pending_items.push_back(offer_item(8'h3C, 1'b0));     // arrives during the latch
        pending_items.push_back(tick_item());
        pending_items.push_back(tick_item());
        pending_items.push_back(offer_item(8'h81, 1'b0));     // later runs dry: underrun
        settle_encoder();

        // Random settings, defaults and extremes among them
        run_setting(RST_ZERO_HIGH, RST_ONE_HIGH, RST_BIT_PERIOD, RST_LATCH, 120, 1'b0, 1'b0, 1'b0);
        run_setting(8'd1, 8'd2, 8'd3, 16'd4, 300, 1'b1, 1'b1, 1'b0);
        run_setting(8'd2, 8'd1, 8'd2, 16'd1, 200, 1'b1, 1'b0, 1'b0);
        run_setting(8'd7, 8'd254, 8'd8, 16'd40, 100, 1'b0, 1'b0, 1'b1);
        run_setting(8'd1, 8'd1, 8'd0, 16'd0, 150, 1'b1, 1'b0, 1'b0);
        run_setting(8'd1, 8'd255, 8'd1, 16'd2, 120, 1'b1, 1'b0, 1'b0);
        for (k = 0; k < 3; k++)
            run_setting(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                        8'($urandom_range(2, 8)), 16'($urandom_range(1, 40)),
                        40, 1'b1, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Ran %0d input transactions over %0d timing settings; %0d results checked.",
                 items_in, settings_run, results_seen);
        $display("Encoder took %0d bytes and latched %0d frames.", bytes_taken, frames_latched);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(50_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
